@@ rtl/falu_pkg.sv @@
// Shared types and constants of the fixed-point ALU.
package falu_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DivW      = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_LT  = 4'd4, CMD_LE  = 4'd5, CMD_GT  = 4'd6, CMD_GE  = 4'd7,
    CMD_EQ  = 4'd8, CMD_NE  = 4'd9, CMD_INC = 4'd10, CMD_DEC = 4'd11,
    CMD_MIN = 4'd12, CMD_MAX = 4'd13, CMD_TO_INT = 4'd14, CMD_FROM_INT = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_PLAIN = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  res;
    logic         cmp;
    status_e      st;
    logic [31:0]  a;
    logic [31:0]  b;
  } fitem_t;

  typedef struct packed {
    logic         valid;
    kind_e        kind;
    logic [31:0]  res;
    logic         cmp;
    status_e      st;
    logic         neg;
    logic [31:0]  r;
    logic [63:0]  n;
    logic [31:0]  d;
  } bitem_t;

endpackage

@@ rtl/falu_front.sv @@
// Front end: decode the command, finish simple ops, mark mul and div items.
module falu_front import falu_pkg::*; (
  input  logic [3:0]  cmd_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output fitem_t      item_o
);

  logic signed [31:0] sa, sb;
  logic               lt, eq;

  assign sa = $signed(a_i);
  assign sb = $signed(b_i);
  assign lt = sa < sb;
  assign eq = a_i == b_i;

  always_comb begin
    item_o      = '0;
    item_o.kind = K_PLAIN;
    item_o.st   = ST_OK;
    item_o.a    = a_i;
    item_o.b    = b_i;
    case (cmd_e'(cmd_i))
      CMD_ADD:      item_o.res = a_i + b_i;
      CMD_SUB:      item_o.res = a_i - b_i;
      CMD_MUL:      item_o.kind = K_MUL;
      CMD_DIV: begin
        if (b_i == 32'd0) begin
          item_o.st = ST_DIVZ;
        end else begin
          item_o.kind = K_DIV;
        end
      end
      CMD_LT:       item_o.cmp = lt;
      CMD_LE:       item_o.cmp = lt | eq;
      CMD_GT:       item_o.cmp = ~(lt | eq);
      CMD_GE:       item_o.cmp = ~lt;
      CMD_EQ:       item_o.cmp = eq;
      CMD_NE:       item_o.cmp = ~eq;
      CMD_INC:      item_o.res = a_i + 32'd1;
      CMD_DEC:      item_o.res = a_i - 32'd1;
      CMD_MIN:      item_o.res = lt ? a_i : b_i;
      CMD_MAX:      item_o.res = (!lt && !eq) ? a_i : b_i;
      CMD_TO_INT:   item_o.res = 32'(sa >>> FRAC_BITS);
      CMD_FROM_INT: item_o.res = a_i << FRAC_BITS;
      default:      item_o.res = '0;
    endcase
  end

endmodule

@@ rtl/falu_queue.sv @@
// Two-entry queue between front and back end.
module falu_queue import falu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  fitem_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output fitem_t data_o
);

  fitem_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/falu_back.sv @@
// Back end: multiply, pipelined restoring divider, saturation, output register.
module falu_back import falu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  fitem_t      q_data_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [31:0] res_o,
  output logic        cmp_o,
  output logic [1:0]  st_o
);

  bitem_t pipe_q [DivW+1];
  bitem_t head;
  logic   en;
  logic   out_valid_q;
  logic [31:0] out_res_q;
  logic        out_cmp_q;
  status_e     out_st_q;
  logic signed [31:0] sa, sb;
  logic signed [63:0] prod;
  logic [31:0] mag_a, mag_b;
  logic [31:0] fin_res;
  status_e     fin_st;
  logic signed [63:0] p, adj, mq;
  logic [63:0] qm;

  assign en      = !out_valid_q || m_ready_i;
  assign q_pop_o = en;

  assign sa    = $signed(q_data_i.a);
  assign sb    = $signed(q_data_i.b);
  assign prod  = sa * sb;
  assign mag_a = q_data_i.a[31] ? -q_data_i.a : q_data_i.a;
  assign mag_b = q_data_i.b[31] ? -q_data_i.b : q_data_i.b;

  always_comb begin
    head       = '0;
    head.valid = q_valid_i;
    head.kind  = q_data_i.kind;
    head.res   = q_data_i.res;
    head.cmp   = q_data_i.cmp;
    head.st    = q_data_i.st;
    head.neg   = q_data_i.a[31] ^ q_data_i.b[31];
    head.d     = mag_b;
    case (q_data_i.kind)
      K_MUL:   head.n = prod;
      K_DIV:   head.n = {32'd0, mag_a} << FRAC_BITS;
      default: head.n = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[0] <= '0;
    end else if (en) begin
      pipe_q[0] <= head;
    end
  end

  for (genvar i = 1; i <= DivW; i++) begin : g_div
    logic [32:0] t;
    logic        ge;
    bitem_t      nx;
    assign t  = {pipe_q[i-1].r, pipe_q[i-1].n[DivW-1]};
    assign ge = t >= {1'b0, pipe_q[i-1].d};
    always_comb begin
      nx = pipe_q[i-1];
      if (pipe_q[i-1].kind == K_DIV) begin
        nx.r = ge ? 32'(t - {1'b0, pipe_q[i-1].d}) : t[31:0];
        nx.n = {pipe_q[i-1].n[62:0], ge};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[i] <= '0;
      end else if (en) begin
        pipe_q[i] <= nx;
      end
    end
  end

  assign p   = $signed(pipe_q[DivW].n);
  assign adj = p + (p[63] ? 64'sd1 * ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
  assign qm  = {{(64-DivW){1'b0}}, pipe_q[DivW].n[DivW-1:0]};
  assign mq  = adj >>> FRAC_BITS;

  always_comb begin
    fin_res = pipe_q[DivW].res;
    fin_st  = pipe_q[DivW].st;
    case (pipe_q[DivW].kind)
      K_MUL: begin
        if (mq > 64'sd2147483647) begin
          fin_res = 32'h7FFF_FFFF;
          fin_st  = ST_OVF;
        end else if (mq < -64'sd2147483648) begin
          fin_res = 32'h8000_0000;
          fin_st  = ST_OVF;
        end else begin
          fin_res = mq[31:0];
        end
      end
      K_DIV: begin
        if (pipe_q[DivW].neg) begin
          if (qm > 64'h8000_0000) begin
            fin_res = 32'h8000_0000;
            fin_st  = ST_OVF;
          end else begin
            fin_res = -qm[31:0];
          end
        end else if (qm > 64'h7FFF_FFFF) begin
          fin_res = 32'h7FFF_FFFF;
          fin_st  = ST_OVF;
        end else begin
          fin_res = qm[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pipe_q[DivW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= fin_res;
      out_cmp_q <= pipe_q[DivW].cmp;
      out_st_q  <= fin_st;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = out_res_q;
  assign cmp_o     = out_cmp_q;
  assign st_o      = out_st_q;

endmodule

@@ rtl/fixed_point_alu.sv @@
// Top level of the signed 32-bit fixed-point ALU.
// channel | direction | signals                      | contents
// input   | slave     | s_axis_tvalid/tready/tdata/tuser | cmd, operand_a, operand_b
// output  | master    | m_axis_tvalid/tready/tdata   | result, compare_true, status
// One item enters per cycle while the queue is not full; each result passes
// through the queue and the one-bit-per-stage divider pipeline all items go through.
// A stalled output freezes the whole back pipeline; the two-entry queue
// keeps accepting until full. Reset clears all valid flags at once.
module fixed_point_alu import falu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  s_axis_tuser,   // cmd[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result[31:0], compare_true[32], status[34:33]
);

  fitem_t      fitem, qitem;
  logic        full, q_valid, q_pop;
  logic [31:0] res;
  logic        cmp;
  logic [1:0]  st;

  falu_front u_front (
    .cmd_i  (s_axis_tuser),
    .a_i    (s_axis_tdata[31:0]),
    .b_i    (s_axis_tdata[63:32]),
    .item_o (fitem)
  );

  falu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (fitem),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (qitem)
  );

  falu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (qitem),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res),
    .cmp_o     (cmp),
    .st_o      (st)
  );

  assign s_axis_tready = !full;
  assign m_axis_tdata  = {5'd0, st, cmp, res};

  a_no_bad_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
    else $error("undefined status code");

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[34:33] == ST_DIVZ) |->
      (m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32]))
    else $error("divide by zero item carries data");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[32]) |->
      (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[34:33] == ST_OK))
    else $error("comparison item carries result or status");

endmodule
